// File: rtl/core/rmrs_pkg.sv
package rmrs_pkg;

  // Operation select for the shared adder.
  typedef struct packed {
    logic subtract;  // Add the ones complement of b plus one.
    logic zero_a;    // Force the a operand to zero (pass or negate b).
  } alu_ctl_t;

endpackage

// File: rtl/core/rmrs_ram.sv
module rmrs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/rmrs_alu.sv
module rmrs_alu import rmrs_pkg::*; #(
  parameter int AW = 28
) (
  input  alu_ctl_t      ctl,
  input  logic [AW-1:0] a,
  input  logic [AW-1:0] b,
  output logic [AW-1:0] sum
);

  logic [AW-1:0] a_op;
  logic [AW-1:0] b_op;

  always_comb begin
    a_op = ctl.zero_a ? '0 : a;
    b_op = ctl.subtract ? ~b : b;
    sum  = a_op + b_op + AW'(ctl.subtract);
  end

endmodule

// File: rtl/core/running_mean_ring_smoother.sv
// Channel | Direction | tdata (low bit up)            | tuser
// in_     | slave     | sample_value, zero padding    | -
// out_    | master    | mean_value, zero padding      | window_full
//
// An item passes from acceptance through the SUB, ADD, ABS, DIV and NEG steps to the
// result register; the restoring divider produces one quotient bit per cycle on the
// shared adder. in_tready is high only between items.
// A finished result waits in the output register while the next word is taken.
// Reset needs no clearing pass: slots not yet written are read as zero by fill count.
// A stalled output holds the sequencer in its final step until the register frees.
module running_mean_ring_smoother import rmrs_pkg::*; #(
  parameter int WINDOW_DEPTH = 8,
  parameter int SAMPLE_BITS  = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     in_tdata,   // sample_value
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]     out_tdata,  // mean_value
  output logic                                 out_tuser   // window_full
);

  localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int IW = $clog2(WINDOW_DEPTH);
  localparam int CW = $clog2(WINDOW_DEPTH + 1);
  localparam int TW = SAMPLE_BITS + IW;
  localparam int AW = TW + 1;
  localparam int NW = $clog2(TW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_ADD,
    ST_ABS,
    ST_DIV,
    ST_NEG
  } state_t;

  state_t                 state_r, state_nxt;
  logic [IW-1:0]          slot_r, slot_nxt;
  logic [CW-1:0]          fill_r, fill_nxt;
  logic [TW-1:0]          total_r, total_nxt;
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;
  logic [TW-1:0]          quo_r, quo_nxt;
  logic [CW-1:0]          rem_r, rem_nxt;
  logic [NW-1:0]          cnt_r, cnt_nxt;
  logic                   neg_r, neg_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [SAMPLE_BITS-1:0] mean_r, mean_nxt;
  logic                   full_r, full_nxt;

  logic                   in_fire;
  logic                   out_free;
  logic                   win_full;
  logic [SAMPLE_BITS-1:0] old_sample;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic                   ram_we;
  logic [CW:0]            shifted;
  logic                   ge;

  alu_ctl_t               alu_ctl;
  logic [AW-1:0]          alu_a;
  logic [AW-1:0]          alu_b;
  logic [AW-1:0]          alu_sum;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign win_full  = (fill_r == CW'(WINDOW_DEPTH));

  // The slot under the write index has been written only once the window is full.
  assign old_sample = win_full ? ram_rdata : '0;
  assign shifted    = {rem_r, quo_r[TW-1]};
  assign ge         = !alu_sum[AW-1];
  assign ram_we     = (state_r == ST_ADD);

  rmrs_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(WINDOW_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (sample_r),
    .re    (in_fire),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  rmrs_alu #(
    .AW(AW)
  ) u_alu (
    .ctl (alu_ctl),
    .a   (alu_a),
    .b   (alu_b),
    .sum (alu_sum)
  );

  always_comb begin
    alu_ctl = '0;
    alu_a   = {total_r[TW-1], total_r};
    alu_b   = '0;
    case (state_r)
      ST_SUB: begin
        alu_ctl.subtract = 1'b1;
        alu_b = {{(AW-SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample};
      end
      ST_ADD: begin
        alu_b = {{(AW-SAMPLE_BITS){sample_r[SAMPLE_BITS-1]}}, sample_r};
      end
      ST_ABS: begin
        alu_ctl.zero_a   = 1'b1;
        alu_ctl.subtract = total_r[TW-1];
        alu_b = {total_r[TW-1], total_r};
      end
      ST_DIV: begin
        // Trial subtraction of the divisor from the shifted partial remainder.
        alu_ctl.subtract = 1'b1;
        alu_a = AW'(shifted);
        alu_b = AW'(fill_r);
      end
      ST_NEG: begin
        alu_ctl.zero_a   = 1'b1;
        alu_ctl.subtract = neg_r;
        alu_b = AW'(quo_r);
      end
      default: begin
        alu_ctl = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    total_nxt     = total_r;
    sample_nxt    = sample_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_tready;
    mean_nxt      = mean_r;
    full_nxt      = full_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          sample_nxt = in_tdata[SAMPLE_BITS-1:0];
          state_nxt  = ST_SUB;
        end
      end
      ST_SUB: begin
        total_nxt = alu_sum[TW-1:0];
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        total_nxt = alu_sum[TW-1:0];
        slot_nxt  = (slot_r == IW'(WINDOW_DEPTH - 1)) ? '0 : slot_r + 1'b1;
        if (!win_full) begin
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt = ST_ABS;
      end
      ST_ABS: begin
        neg_nxt   = total_r[TW-1];
        quo_nxt   = alu_sum[TW-1:0];
        rem_nxt   = '0;
        cnt_nxt   = NW'(TW - 1);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = ge ? alu_sum[CW-1:0] : shifted[CW-1:0];
        quo_nxt = {quo_r[TW-2:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_NEG;
        end
      end
      ST_NEG: begin
        if (out_free) begin
          mean_nxt      = alu_sum[SAMPLE_BITS-1:0];
          full_nxt      = win_full;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slot_r      <= '0;
      fill_r      <= '0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sample_r <= sample_nxt;
    quo_r    <= quo_nxt;
    rem_r    <= rem_nxt;
    cnt_r    <= cnt_nxt;
    neg_r    <= neg_nxt;
    mean_r   <= mean_nxt;
    full_r   <= full_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = DW'(mean_r);
  assign out_tuser  = full_r;

endmodule

// File: rtl/core/rmrs_chk.sv
module rmrs_chk #(
  parameter int DW = 24
) (
  input logic          clk,
  input logic          rst_n,
  input logic          in_tvalid,
  input logic          in_tready,
  input logic [DW-1:0] in_tdata,
  input logic          out_tvalid,
  input logic          out_tready,
  input logic [DW-1:0] out_tdata,
  input logic          out_tuser
);

  // A stalled result word must stay offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word dropped or changed while stalled");

  // The block is ready for a word right after reset.
  a_ready_after_reset: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> in_tready)
    else $error("not ready after reset");

  // One word at a time: taking a word closes the input.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still open after a word was taken");

  // The result of a new word cannot appear in the cycle after it is taken.
  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !$rose(out_tvalid))
    else $error("result appeared too early");

  // While the sequencer is idle no result is loaded, so a taken word empties the register.
  a_drain_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && in_tready |=> !out_tvalid)
    else $error("result register refilled while idle");

endmodule

bind running_mean_ring_smoother rmrs_chk #(
  .DW(((SAMPLE_BITS + 7) / 8) * 8)
) u_rmrs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
